>>> src/button_click_classifier_core_assert.svh
// Assertion macros shared by the classifier core.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("classifier core: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("classifier core: next-cycle check failed");

`endif

>>> src/bcc_pkg.sv
package bcc_pkg;

  // Result kinds reported for each sample.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_LONG   = 2'd2,
    EV_LONGER = 2'd3
  } event_kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ACTIVE_LEVEL = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_MULTI_CLICK  = 3'd2,
    REG_LONG_CLICK   = 3'd3,
    REG_LONGER_CLICK = 3'd4
  } cfg_index_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CLICKS_W   = 8;

  // Reset values of the configuration registers.
  localparam logic                  RST_ACTIVE_LEVEL = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE     = 16'd30;
  localparam logic [CFG_DATA_W-1:0] RST_MULTI_CLICK  = 16'd600;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_CLICK   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_LONGER_CLICK = 16'd2000;

  localparam logic [CLICKS_W-1:0] CLICKS_MAX = 8'd255;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    logic                  active_level;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] multi_click_ms;
    logic [CFG_DATA_W-1:0] long_click_ms;
    logic [CFG_DATA_W-1:0] longer_click_ms;
  } cfg_t;

  // One classified result.
  typedef struct packed {
    event_kind_t         kind;
    logic [CLICKS_W-1:0] clicks;
  } result_t;

endpackage

>>> src/button_click_classifier_core.sv
// Button click classifier core.
// Input channel: in_valid / in_stall with in_now_ms (millisecond timestamp)
// and in_pin_level (raw pin sample). A request is taken at a clock edge with
// in_valid high and in_stall low.
// Result channel: out_valid / out_stall with out_event_kind (none, click,
// long press, longer press) and out_clicks (count for a click, else zero).
// Every input request yields exactly one result request, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_wdata; the port
// is always ready. Write it only while no sample is in flight.
// A sample passes through the input register, is classified against the held
// state and lands in the result register.
// Throughput is one sample per cycle while out_stall is low, set by the
// single classify step whose state update feeds the next sample directly.
// When the receiver stalls, the result register holds its request and the
// input register fills; in_stall rises only when both are occupied.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and returns the button state to released.
`include "button_click_classifier_core_assert.svh"

module button_click_classifier_core
  import bcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  in_pin_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic [CLICKS_W-1:0]   out_clicks,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_pin_r;
  logic              out_valid_r;
  result_t           out_res_r;

  logic    out_load;
  logic    advance;
  logic    in_take;
  cfg_t    cfg;
  result_t step_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  bcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Handshake: the result register frees when empty or being taken.
  assign out_load = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= in_now_ms;
      s1_pin_r <= in_pin_level;
    end
  end

  // Classification step with its button state.
  bcc_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .now_ms    (s1_now_r),
    .pin_level (s1_pin_r),
    .cfg       (cfg),
    .res       (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_res_r.kind;
  assign out_clicks     = out_res_r.clicks;

  // A click always carries a nonzero count; other kinds carry zero.
  `BCC_ASSERT_NOW(a_click_count, out_valid_r && (out_res_r.kind == EV_CLICK), out_res_r.clicks != '0)
  `BCC_ASSERT_NOW(a_other_zero, out_valid_r && (out_res_r.kind != EV_CLICK), out_res_r.clicks == '0)
  // The input side only backs up when the result register is held.
  `BCC_ASSERT_NOW(a_stall_cause, in_stall, out_valid_r && out_stall && s1_valid_r)
  // A sample moved forward always shows up as a result next cycle.
  `BCC_ASSERT_NEXT(a_advance_out, advance, out_valid_r)

endmodule

>>> src/bcc_cfg_regs.sv
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level    <= RST_ACTIVE_LEVEL;
      cfg_r.debounce_ms     <= RST_DEBOUNCE;
      cfg_r.multi_click_ms  <= RST_MULTI_CLICK;
      cfg_r.long_click_ms   <= RST_LONG_CLICK;
      cfg_r.longer_click_ms <= RST_LONGER_CLICK;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        REG_ACTIVE_LEVEL: cfg_r.active_level    <= wr_data[0];
        REG_DEBOUNCE:     cfg_r.debounce_ms     <= wr_data;
        REG_MULTI_CLICK:  cfg_r.multi_click_ms  <= wr_data;
        REG_LONG_CLICK:   cfg_r.long_click_ms   <= wr_data;
        REG_LONGER_CLICK: cfg_r.longer_click_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/bcc_step.sv
module bcc_step
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pin_level,
  input  cfg_t              cfg,
  output result_t           res
);

  logic                were_released_r, were_released_nxt;
  logic [TIME_W-1:0]   press_time_r, press_time_nxt;
  logic [TIME_W-1:0]   last_click_r, last_click_nxt;
  logic [CLICKS_W-1:0] click_count_r, click_count_nxt;

  logic              pressed;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] gap;
  logic              ge_debounce, lt_long, ge_long, ge_longer, in_window;

  // Time differences wrap at the counter width.
  assign pressed     = (pin_level == cfg.active_level);
  assign held        = now_ms - press_time_r;
  assign gap         = now_ms - last_click_r;
  assign ge_debounce = (held >= TIME_W'(cfg.debounce_ms));
  assign lt_long     = (held <  TIME_W'(cfg.long_click_ms));
  assign ge_long     = !lt_long;
  assign ge_longer   = (held >= TIME_W'(cfg.longer_click_ms));
  assign in_window   = (gap  <  TIME_W'(cfg.multi_click_ms));

  // Classify the sample and work out the next state.
  always_comb begin
    were_released_nxt = were_released_r;
    press_time_nxt    = press_time_r;
    last_click_nxt    = last_click_r;
    click_count_nxt   = click_count_r;
    res.kind          = EV_NONE;
    res.clicks        = '0;
    if (pressed && were_released_r) begin
      // Press edge: start timing the hold.
      press_time_nxt    = now_ms;
      were_released_nxt = 1'b0;
    end else if (!pressed && !were_released_r) begin
      // Release edge: a click if the hold fell inside the click window.
      were_released_nxt = 1'b1;
      if (ge_debounce && lt_long) begin
        if (in_window) begin
          if (click_count_r != CLICKS_MAX) begin
            click_count_nxt = click_count_r + CLICKS_W'(1);
          end
        end else begin
          click_count_nxt = CLICKS_W'(1);
        end
        last_click_nxt = now_ms;
        res.kind       = EV_CLICK;
        res.clicks     = click_count_nxt;
      end
    end else if (pressed) begin
      // Still held: the longer threshold wins over the long one.
      if (ge_longer) begin
        res.kind = EV_LONGER;
      end else if (ge_long) begin
        res.kind = EV_LONG;
      end
    end
  end

  // State advances once per sample that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      were_released_r <= 1'b1;
      press_time_r    <= '0;
      last_click_r    <= '0;
      click_count_r   <= CLICKS_W'(1);
    end else if (advance) begin
      were_released_r <= were_released_nxt;
      press_time_r    <= press_time_nxt;
      last_click_r    <= last_click_nxt;
      click_count_r   <= click_count_nxt;
    end
  end

endmodule

>>> verif/tb_button_click_classifier_core.sv
module tb_button_click_classifier_core;
  import bcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 250000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 6;
  localparam int unsigned SATURATE_CLICKS  = 260;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              pin;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  in_pin_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_event_kind;
  logic [CLICKS_W-1:0]   out_clicks;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  button_click_classifier_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_ms      (in_now_ms),
    .in_pin_level   (in_pin_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_clicks     (out_clicks),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus waiting to be offered, and classifications waiting to come out.
  sample_t pending_samples[$];
  result_t predicted_events[$];

  // Classifier state and configuration as the testbench tracks them.
  cfg_t              live_cfg;
  logic              btn_released = 1'b1;
  logic [TIME_W-1:0] press_start_ms = '0;
  logic [TIME_W-1:0] last_click_ms = '0;
  logic [CLICKS_W-1:0] click_run = 8'd1;

  // Idling controls, set per phase.
  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  logic        hold_armed = 1'b0;
  logic        hold_fired = 1'b0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned settings_used = 1;
  int unsigned click_seen = 0;
  int unsigned long_seen = 0;
  int unsigned longer_seen = 0;
  int unsigned top_clicks = 0;
  logic [TIME_W-1:0] sim_ms = '0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Classify one sample against the tracked state and queue the outcome.
  function automatic void classify_sample(input logic [TIME_W-1:0] now, input logic pin);
    result_t           r;
    logic              pressed;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_click;
    r.kind = EV_NONE;
    r.clicks = '0;
    pressed = (pin == live_cfg.active_level);
    held = now - press_start_ms;
    since_click = now - last_click_ms;
    if (pressed && btn_released) begin
      press_start_ms = now;
      btn_released = 1'b0;
    end else if (!pressed && !btn_released) begin
      btn_released = 1'b1;
      if (held >= TIME_W'(live_cfg.debounce_ms) && held < TIME_W'(live_cfg.long_click_ms)) begin
        if (since_click < TIME_W'(live_cfg.multi_click_ms)) begin
          if (click_run < CLICKS_MAX) click_run++;
        end else begin
          click_run = 8'd1;
        end
        last_click_ms = now;
        r.kind = EV_CLICK;
        r.clicks = click_run;
      end
    end else if (pressed) begin
      if (held >= TIME_W'(live_cfg.longer_click_ms)) r.kind = EV_LONGER;
      else if (held >= TIME_W'(live_cfg.long_click_ms)) r.kind = EV_LONG;
    end
    predicted_events.push_back(r);
  endfunction

  // Sample driver: offers queued samples, holds each until its request is taken.
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    int unsigned in_wait;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        classify_sample(in_now_ms, in_pin_level);
        samples_sent++;
        in_wait = $urandom_range(0, in_gap_max);
      end
      if (!in_valid || !in_stall) begin
        if (in_wait != 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          nxt = pending_samples.pop_front();
          in_now_ms <= nxt.now_ms;
          in_pin_level <= nxt.pin;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken request and draws the next stall.
  always @(posedge clk) begin : watch_results
    result_t want;
    int unsigned out_wait;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d clicks %0d",
                                    out_event_kind, out_clicks));
        end else begin
          want = predicted_events.pop_front();
          if (out_event_kind !== want.kind)
            report_mismatch($sformatf("event kind %0d, expected %s",
                                      out_event_kind, want.kind.name()));
          if (out_clicks !== want.clicks)
            report_mismatch($sformatf("clicks %0d, expected %0d", out_clicks, want.clicks));
          case (want.kind)
            EV_CLICK:  click_seen++;
            EV_LONG:   long_seen++;
            EV_LONGER: longer_seen++;
            default: ;
          endcase
          if (32'(want.clicks) > top_clicks) top_clicks = 32'(want.clicks);
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (out_wait != 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One long receiver hold-off, so the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_fired <= 1'b0;
    end else if (hold_armed && !hold_fired) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, predicted_events.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_sample(input logic [TIME_W-1:0] t, input logic pin);
    pending_samples.push_back('{now_ms: t, pin: pin});
  endtask

  // Write one register and mirror it into the tracked configuration.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ACTIVE_LEVEL: live_cfg.active_level = data[0];
      REG_DEBOUNCE:     live_cfg.debounce_ms = data;
      REG_MULTI_CLICK:  live_cfg.multi_click_ms = data;
      REG_LONG_CLICK:   live_cfg.long_click_ms = data;
      REG_LONGER_CLICK: live_cfg.longer_click_ms = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic act, input logic [CFG_DATA_W-1:0] deb,
                               input logic [CFG_DATA_W-1:0] multi,
                               input logic [CFG_DATA_W-1:0] long_ms,
                               input logic [CFG_DATA_W-1:0] longer_ms);
    write_register(REG_ACTIVE_LEVEL, CFG_DATA_W'(act));
    write_register(REG_DEBOUNCE, deb);
    write_register(REG_MULTI_CLICK, multi);
    write_register(REG_LONG_CLICK, long_ms);
    write_register(REG_LONGER_CLICK, longer_ms);
    settings_used++;
  endtask

  // Wait until every sample was taken and every classification came back.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || predicted_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold durations clustered on the thresholds of the current setting.
  function automatic logic [TIME_W-1:0] pick_hold();
    logic [TIME_W-1:0] deb;
    logic [TIME_W-1:0] lng;
    logic [TIME_W-1:0] lgr;
    deb = TIME_W'(live_cfg.debounce_ms);
    lng = TIME_W'(live_cfg.long_click_ms);
    lgr = TIME_W'(live_cfg.longer_click_ms);
    case ($urandom_range(0, 9))
      0: return deb - 1;
      1: return deb;
      2: return lng - 1;
      3: return lng;
      4: return lgr - 1;
      5: return lgr;
      6: return (deb < lng) ? $urandom_range(deb, lng - 1) : deb;
      7: return $urandom_range(0, 100);
      8: return $urandom_range(0, 70000);
      default: return lgr + $urandom_range(0, 1000);
    endcase
  endfunction

  // Release-to-release distances clustered on the multi-click window.
  function automatic logic [TIME_W-1:0] pick_spacing();
    logic [TIME_W-1:0] win;
    win = TIME_W'(live_cfg.multi_click_ms);
    case ($urandom_range(0, 5))
      0: return win - 1;
      1: return win;
      2: return win + 1;
      3: return $urandom_range(0, win);
      4: return $urandom_range(0, 100);
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  // Press gestures with random content, mixed with stray samples.
  task automatic run_mixed(input int unsigned n_items, input int unsigned noise_pct);
    int unsigned pushed;
    int unsigned mids;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] spacing;
    logic [TIME_W-1:0] press_at;
    pushed = 0;
    sim_ms = $urandom;
    while (pushed < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_sample($urandom, 1'($urandom_range(0, 1)));
        pushed++;
      end else begin
        hold = pick_hold();
        spacing = pick_spacing();
        mids = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        press_at = sim_ms + ((spacing >= hold) ? spacing - hold : 0);
        push_sample(press_at, live_cfg.active_level);
        for (int unsigned i = 1; i <= mids; i++)
          push_sample(press_at + TIME_W'((longint'(hold) * i) / (mids + 1)),
                      live_cfg.active_level);
        pushed += 1 + mids;
        sim_ms = press_at + hold;
        // An occasional gesture is cut off without its release.
        if ($urandom_range(0, 9) != 0) begin
          push_sample(sim_ms, !live_cfg.active_level);
          pushed++;
        end
      end
    end
  endtask

  initial begin
    live_cfg.active_level = RST_ACTIVE_LEVEL;
    live_cfg.debounce_ms = RST_DEBOUNCE;
    live_cfg.multi_click_ms = RST_MULTI_CLICK;
    live_cfg.long_click_ms = RST_LONG_CLICK;
    live_cfg.longer_click_ms = RST_LONGER_CLICK;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples on the reset setting, where a low pin means pressed.
    push_sample(32'd100, 1'b1);
    push_sample(32'd1000, 1'b0);
    push_sample(32'd1020, 1'b0);
    push_sample(32'd1040, 1'b1);
    push_sample(32'd1100, 1'b0);
    push_sample(32'd1200, 1'b1);
    push_sample(32'd1300, 1'b0);
    push_sample(32'd1310, 1'b1);
    push_sample(32'd1400, 1'b0);
    push_sample(32'd1429, 1'b1);
    push_sample(32'd1500, 1'b0);
    push_sample(32'd1530, 1'b1);
    push_sample(32'd1600, 1'b0);
    push_sample(32'd2099, 1'b1);
    push_sample(32'd3000, 1'b0);
    push_sample(32'd3499, 1'b0);
    push_sample(32'd3500, 1'b0);
    push_sample(32'd4999, 1'b0);
    push_sample(32'd5000, 1'b0);
    push_sample(32'd5001, 1'b1);
    // A press that spans the wrap of the millisecond counter.
    push_sample(32'hFFFF_FFF0, 1'b0);
    push_sample(32'h0000_0040, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Chained clicks with an open window, so the count saturates; the
    // receiver holds off first while samples keep coming.
    apply_setting(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    in_gap_max = 0;
    out_gap_max = 5;
    hold_armed = 1'b1;
    sim_ms = $urandom;
    for (int unsigned i = 0; i < SATURATE_CLICKS; i++) begin
      sim_ms += $urandom_range(0, 200);
      push_sample(sim_ms, 1'b1);
      sim_ms += $urandom_range(0, 400);
      push_sample(sim_ms, 1'b0);
    end
    wait_drained();

    // Opposite extremes: no click can qualify and every held sample is longer.
    apply_setting(1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    in_gap_max = 19;
    out_gap_max = 19;
    run_mixed(40, 20);
    wait_drained();

    apply_setting(1'b1, 16'd20, 16'd300, 16'd200, 16'd400);
    in_gap_max = 19;
    out_gap_max = 0;
    run_mixed(40, 10);
    wait_drained();

    // Longer threshold below the long one, and long below debounce.
    apply_setting(1'b0, 16'd100, 16'hFFFF, 16'd50, 16'd30);
    in_gap_max = 0;
    out_gap_max = 19;
    run_mixed(40, 15);
    wait_drained();

    // Random settings, with writes to unmapped indexes that must be ignored.
    for (int unsigned k = 0; k < 2; k++) begin
      write_register(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                     CFG_DATA_W'($urandom));
      apply_setting(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 600)),
                    CFG_DATA_W'($urandom_range(0, 2000)),
                    CFG_DATA_W'($urandom_range(0, 1500)),
                    CFG_DATA_W'($urandom_range(0, 4000)));
      write_register(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                     CFG_DATA_W'($urandom));
      in_gap_max = (k == 0) ? 19 : 0;
      out_gap_max = 19;
      run_mixed(20, 30);
      wait_drained();
    end

    if (predicted_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_events.size()));
    $display("Ran %0d samples over %0d settings: %0d clicks, %0d long, %0d longer presses",
             samples_sent, settings_used, click_seen, long_seen, longer_seen);
    $display("Highest click count seen %0d, mismatches %0d", top_clicks, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bcc_pkg.sv
src/bcc_cfg_regs.sv
src/bcc_step.sv
src/button_click_classifier_core.sv
verif/tb_button_click_classifier_core.sv
